// File: rtl/core/bged_pkg.sv
// Shared constants, level codes and helper functions for the edge detector.
`timescale 1ns / 1ps

package bged_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COL_W + 1;
  localparam int ROW_W     = 16;
  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 2;
  localparam int LEVEL_W   = 8;

  // Quantized level codes
  localparam int CODE_W = 2;
  localparam logic [CODE_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [CODE_W-1:0] LVL_MID  = 2'd1;
  localparam logic [CODE_W-1:0] LVL_HIGH = 2'd2;

  // Line store word: level of the row above, then the row above that
  localparam int LINE_W = 2 * CODE_W;

  // Gray level thresholds, applied to the channel sum instead of sum / 3
  localparam int MID_LEVEL = 128;
  localparam logic [SUM_W-1:0] SUM_HIGH_MIN  = SUM_W'(3 * (MID_LEVEL + 1));
  localparam logic [SUM_W-1:0] SUM_LOW_LIMIT = SUM_W'(3 * MID_LEVEL);

  localparam logic [LEVEL_W-1:0] LEVEL_MID_VAL  = LEVEL_W'(MID_LEVEL);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 8'd255;
  localparam logic [LEVEL_W:0]   GRAD_THRESHOLD = (LEVEL_W + 1)'(MID_LEVEL);
  localparam logic [LEVEL_W-1:0] EDGE_MARK      = 8'd0;
  localparam logic [LEVEL_W-1:0] NO_EDGE_MARK   = 8'd255;

  // Register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

  // Map a level code to its gray value
  function automatic logic [LEVEL_W-1:0] level_value(input logic [CODE_W-1:0] code);
    logic [LEVEL_W-1:0] val;
    case (code)
      LVL_LOW: val = '0;
      LVL_MID: val = LEVEL_MID_VAL;
      default: val = LEVEL_FULL;
    endcase
    return val;
  endfunction

  // Quantize the sum of the three channels to a level code
  function automatic logic [CODE_W-1:0] quantize(input logic [SUM_W-1:0] sum);
    logic [CODE_W-1:0] code;
    if (sum >= SUM_HIGH_MIN) begin
      code = LVL_HIGH;
    end else if (sum < SUM_LOW_LIMIT) begin
      code = LVL_LOW;
    end else begin
      code = LVL_MID;
    end
    return code;
  endfunction

endpackage

// File: rtl/core/binary_gradient_edge_detector.sv
// Top level: pixel quantizer, line store, gradient stage and result register.
// Result path: an accepted pixel is held in the stage 1 register, and the result it
// completes then goes to the result register, from which it can be taken.
// Throughput: one pixel per cycle while the result side is not stalled; the line store
// has one read and one write port, covering the lookahead read and write each pixel needs.
// Reset: clears the row and column counters, the pipeline valids and the registers
// to 640 x 480; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module binary_gradient_edge_detector
  import bged_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Pixel input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    blue,
  // Result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COL_W-1:0]   pos_x,
  output logic [ROW_W-1:0]   pos_y,
  output logic [LEVEL_W-1:0] edge_level,
  output logic               frame_last,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Registers
  logic [WIDTH_W-1:0] frame_width;
  logic [ROW_W-1:0]   frame_height;
  logic               reg_write;
  logic               reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (reg_write) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size
  logic [WIDTH_W-1:0] eff_width;
  logic [ROW_W-1:0]   eff_height;

  always_comb begin
    if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else if (frame_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else begin
      eff_width = frame_width;
    end
    eff_height = (frame_height == '0) ? ROW_W'(1) : frame_height;
  end

  // Handshake between stages
  logic in_fire;
  logic s1_valid;
  logic s1_go;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Raster position and next position
  logic [COL_W-1:0]   column_count;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-1:0]   column_count_next;
  logic [ROW_W-1:0]   row_count_next;
  logic [WIDTH_W-1:0] col_inc;
  logic [WIDTH_W-1:0] col_inc2;
  logic [ROW_W:0]     row_inc;
  logic               col_wrap;
  logic               row_wrap;
  logic               emit;
  logic               last;

  always_comb begin
    col_inc  = {1'b0, column_count} + WIDTH_W'(1);
    col_inc2 = col_inc + WIDTH_W'(1);
    row_inc  = {1'b0, row_count} + (ROW_W + 1)'(1);
    col_wrap = col_inc >= eff_width;
    row_wrap = row_inc >= {1'b0, eff_height};
    column_count_next = col_wrap ? '0 : col_inc[COL_W-1:0];
    if (!col_wrap) begin
      row_count_next = row_count;
    end else if (row_wrap) begin
      row_count_next = '0;
    end else begin
      row_count_next = row_inc[ROW_W-1:0];
    end
    // Interior pixel one row up gets its result with this pixel
    emit = (row_count >= ROW_W'(2)) && (row_inc <= {1'b0, eff_height}) &&
           (column_count != '0) && (col_inc2 <= eff_width);
    last = (col_inc2 == eff_width) && (row_inc == {1'b0, eff_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Channel sum and level code of the incoming pixel
  logic [SUM_W-1:0]  chan_sum;
  logic [CODE_W-1:0] in_code;

  assign chan_sum = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign in_code  = quantize(chan_sum);

  // Stage 1 register
  logic [CODE_W-1:0] s1_code;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_pos_y;
  logic              s1_emit;
  logic              s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code  <= in_code;
      s1_col   <= column_count;
      s1_pos_y <= row_count - ROW_W'(1);
      s1_emit  <= emit;
      s1_last  <= last;
    end
  end

  // Line store: read the next column ahead, write the current one in stage 1
  logic [LINE_W-1:0] ahead_word;
  logic [LINE_W-1:0] cur_word;
  logic [CODE_W-1:0] left_levels;
  logic [CODE_W-1:0] above_code;
  logic [CODE_W-1:0] above2_code;
  logic [CODE_W-1:0] right_code;
  logic [LINE_W-1:0] store_wdata;

  assign above_code  = cur_word[LINE_W-1:CODE_W];
  assign above2_code = cur_word[CODE_W-1:0];
  assign right_code  = ahead_word[LINE_W-1:CODE_W];
  assign store_wdata = {s1_code, above_code};

  bged_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata (store_wdata),
    .re    (in_fire),
    .raddr (column_count_next),
    .rdata (ahead_word)
  );

  // Advance the column window as each item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_go) begin
      cur_word <= ahead_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_levels <= LVL_LOW;
    end else if (s1_go) begin
      left_levels <= above_code;
    end
  end

  // Edge decision
  logic [LEVEL_W-1:0] s1_edge_level;

  bged_grad u_grad (
    .left_code   (left_levels),
    .right_code  (right_code),
    .top_code    (above2_code),
    .bottom_code (s1_code),
    .edge_level  (s1_edge_level)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      pos_x      <= s1_col;
      pos_y      <= s1_pos_y;
      edge_level <= s1_edge_level;
      frame_last <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  // Stage 1 holds its item while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col) && $stable(s1_code))
    else $error("stage 1 item changed while stalled");

  // No item is taken when both stages are full and blocked
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is full");

  // An accepted item always lands in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item lost before stage 1");

  // Results only come from interior positions
  a_interior: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit |-> (s1_col != '0) && (s1_pos_y != '0))
    else $error("result scheduled for a border pixel");

  // A result leaving stage 1 shows up at the output
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_emit |=> out_valid)
    else $error("result dropped between stage 1 and output");
`endif

endmodule

// File: rtl/core/bged_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bged_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bged_grad.sv
// Central-difference gradient magnitude and edge decision on level codes.
`timescale 1ns / 1ps

module bged_grad
  import bged_pkg::*;
(
  input  logic [CODE_W-1:0]  left_code,
  input  logic [CODE_W-1:0]  right_code,
  input  logic [CODE_W-1:0]  top_code,
  input  logic [CODE_W-1:0]  bottom_code,
  output logic [LEVEL_W-1:0] edge_level
);

  logic [LEVEL_W-1:0] left_val;
  logic [LEVEL_W-1:0] right_val;
  logic [LEVEL_W-1:0] top_val;
  logic [LEVEL_W-1:0] bottom_val;
  logic [LEVEL_W-1:0] gx;
  logic [LEVEL_W-1:0] gy;
  logic [LEVEL_W:0]   mag;

  // Convert codes to gray levels
  assign left_val   = level_value(left_code);
  assign right_val  = level_value(right_code);
  assign top_val    = level_value(top_code);
  assign bottom_val = level_value(bottom_code);

  // Absolute differences, then the L1 magnitude
  assign gx  = (right_val > left_val) ? (right_val - left_val) : (left_val - right_val);
  assign gy  = (bottom_val > top_val) ? (bottom_val - top_val) : (top_val - bottom_val);
  assign mag = {1'b0, gx} + {1'b0, gy};

  assign edge_level = (mag > GRAD_THRESHOLD) ? EDGE_MARK : NO_EDGE_MARK;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the binary gradient edge detector: directed frame, random frames.
`timescale 1ns / 1ps

module tb_top;
  import bged_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned RANDOM_PIXELS = 1450;
  localparam int unsigned WIDE_PIXELS   = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned MID_GRAY      = 128;
  localparam int unsigned FULL_GRAY     = 255;
  localparam int unsigned GRAD_LIMIT    = 128;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_THRESHOLD,
    FILL_SATURATED,
    FILL_PATCHES
  } fill_mode_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [LEVEL_W-1:0] lvl;
    logic               last;
  } edge_result_t;

  // One pixel of the directed frame; typed rows carry a hand-derived edge level
  typedef struct packed {
    logic [CH_W-1:0]    red_ch;
    logic [CH_W-1:0]    green_ch;
    logic [CH_W-1:0]    blue_ch;
    logic               typed;
    logic [LEVEL_W-1:0] level;
  } stim_row_t;

  // 5 x 4 frame: gray thresholds around 128, saturated channels, flat and edge spots
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{8'd0,   8'd0,   8'd0,   1'b0, EDGE_MARK},
    '{8'd255, 8'd0,   8'd0,   1'b0, EDGE_MARK},
    '{8'd0,   8'd255, 8'd0,   1'b0, EDGE_MARK},
    '{8'd0,   8'd0,   8'd255, 1'b0, EDGE_MARK},
    '{8'd128, 8'd128, 8'd127, 1'b0, EDGE_MARK},
    '{8'd128, 8'd128, 8'd128, 1'b0, EDGE_MARK},
    '{8'd129, 8'd128, 8'd128, 1'b0, EDGE_MARK},
    '{8'd255, 8'd255, 8'd255, 1'b0, EDGE_MARK},
    '{8'd129, 8'd129, 8'd128, 1'b0, EDGE_MARK},
    '{8'd129, 8'd129, 8'd129, 1'b0, EDGE_MARK},
    '{8'd255, 8'd255, 8'd0,   1'b0, EDGE_MARK},
    // horizontal step of 127 only: no edge
    '{8'd0,   8'd0,   8'd0,   1'b1, NO_EDGE_MARK},
    '{8'd255, 8'd255, 8'd255, 1'b1, EDGE_MARK},
    '{8'd255, 8'd0,   8'd255, 1'b1, EDGE_MARK},
    '{8'd0,   8'd0,   8'd0,   1'b0, EDGE_MARK},
    '{8'd0,   8'd0,   8'd0,   1'b0, EDGE_MARK},
    // vertical step of exactly 128: still no edge
    '{8'd127, 8'd127, 8'd127, 1'b1, NO_EDGE_MARK},
    '{8'd128, 8'd128, 8'd128, 1'b1, EDGE_MARK},
    '{8'd255, 8'd255, 8'd255, 1'b1, EDGE_MARK},
    '{8'd0,   8'd0,   8'd0,   1'b0, EDGE_MARK}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid;
  logic               in_ready;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic               out_valid;
  logic               out_ready;
  logic [COL_W-1:0]   pos_x;
  logic [ROW_W-1:0]   pos_y;
  logic [LEVEL_W-1:0] edge_level;
  logic               frame_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predictor state
  logic [WIDTH_W-1:0] cfg_width;
  logic [ROW_W-1:0]   cfg_height;
  bit [CODE_W-1:0]    prev_row [MAX_WIDTH];
  bit [CODE_W-1:0]    older_row [MAX_WIDTH];
  bit [CODE_W-1:0]    left_code;
  int unsigned        col_pos;
  int unsigned        row_pos;
  edge_result_t       pending_edges [$];

  // Run bookkeeping
  rgb_t        last_rgb;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_results;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned results_checked;
  int unsigned settings_run;
  int unsigned cycle_count = 0;

  binary_gradient_edge_detector dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .edge_level (edge_level),
    .frame_last (frame_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_edges.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string what);
    if (mismatches < MAX_REPORTS) begin
      $display("%s", what);
    end
    mismatches++;
  endfunction

  // Idle span for either side: mostly short, now and then long
  function automatic int unsigned idle_span();
    if ($urandom_range(99) < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic int unsigned code_to_gray(input bit [CODE_W-1:0] code);
    case (code)
      LVL_LOW: return 0;
      LVL_MID: return MID_GRAY;
      default: return FULL_GRAY;
    endcase
  endfunction

  function automatic bit [CODE_W-1:0] to_level_code(input rgb_t px);
    int unsigned gray;
    gray = (int'(px.r) + int'(px.g) + int'(px.b)) / 3;
    if (gray > MID_GRAY) begin
      return LVL_HIGH;
    end
    if (gray < MID_GRAY) begin
      return LVL_LOW;
    end
    return LVL_MID;
  endfunction

  function automatic int unsigned gray_step(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic rgb_t make_pixel(input fill_mode_t mode);
    rgb_t       px;
    fill_mode_t pick;
    pick = mode;
    // Patches: mostly repeat the last pixel, else draw a fresh one
    if (mode == FILL_PATCHES) begin
      if ($urandom_range(3) != 0) begin
        return last_rgb;
      end
      pick = fill_mode_t'($urandom_range(2));
    end
    case (pick)
      FILL_THRESHOLD: begin
        px.r = CH_W'($urandom_range(131, 125));
        px.g = CH_W'($urandom_range(131, 125));
        px.b = CH_W'($urandom_range(131, 125));
      end
      FILL_SATURATED: begin
        px.r = $urandom_range(1) ? '1 : '0;
        px.g = $urandom_range(1) ? '1 : '0;
        px.b = $urandom_range(1) ? '1 : '0;
      end
      default: begin
        px.r = CH_W'($urandom_range(255));
        px.g = CH_W'($urandom_range(255));
        px.b = CH_W'($urandom_range(255));
      end
    endcase
    last_rgb = px;
    return px;
  endfunction

  // Advance the predictor by one accepted pixel and queue the result it causes
  task automatic accept_pixel(input rgb_t px, input bit typed, input logic [LEVEL_W-1:0] level);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  rw;
    int unsigned  gx;
    int unsigned  gy;
    bit [CODE_W-1:0] q;
    bit [CODE_W-1:0] up;
    bit [CODE_W-1:0] up2;
    edge_result_t res;
    w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    if (w == 0) begin
      w = 1;
    end
    h = (cfg_height == 0) ? 1 : cfg_height;
    c = col_pos;
    rw = row_pos;
    q = to_level_code(px);
    up = prev_row[c % MAX_WIDTH];
    up2 = older_row[c % MAX_WIDTH];
    if (rw >= 2 && rw + 1 <= h && c >= 1 && c + 2 <= w) begin
      gx = gray_step(code_to_gray(prev_row[(c + 1) % MAX_WIDTH]), code_to_gray(left_code));
      gy = gray_step(code_to_gray(q), code_to_gray(up2));
      res.x = COL_W'(c);
      res.y = ROW_W'(rw - 1);
      res.lvl = (gx + gy > GRAD_LIMIT) ? EDGE_MARK : NO_EDGE_MARK;
      if (typed) begin
        res.lvl = level;
      end
      res.last = (c + 2 == w && rw + 1 == h);
      pending_edges.push_back(res);
    end
    older_row[c % MAX_WIDTH] = up;
    prev_row[c % MAX_WIDTH] = q;
    left_code = up;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (rw + 1 >= h) ? 0 : rw + 1;
    end else begin
      col_pos = c + 1;
    end
    pixels_sent++;
  endtask

  // Offer one pixel, hold it until accepted, then predict
  task automatic send_pixel(input rgb_t px, input bit typed, input logic [LEVEL_W-1:0] level);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(99) < 60) ? 0 : idle_span();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    red <= px.r;
    green <= px.g;
    blue <= px.b;
    do @(posedge clk); while (!in_ready);
    accept_pixel(px, typed, level);
  endtask

  task automatic send_pixels(input int unsigned count, input fill_mode_t mode);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(make_pixel(mode), 1'b0, EDGE_MARK);
    end
  endtask

  // Drop valid, wait for every queued result, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic regsel, input logic [PDATA_W-1:0] wdata,
                           output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {regsel, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic expect_reg(input logic regsel, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    apb_cycle(1'b0, regsel, '0, got);
    if (got !== want) begin
      flag_mismatch($sformatf("register %0d read: expected %0d, got %0d", regsel, want, got));
    end
  endtask

  // Write a register, mirror it in the predictor, read it back
  task automatic program_reg(input logic regsel, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] unused;
    apb_cycle(1'b1, regsel, data, unused);
    if (regsel == REG_FRAME_WIDTH) begin
      cfg_width = data[WIDTH_W-1:0];
      expect_reg(regsel, PDATA_W'(cfg_width));
    end else begin
      cfg_height = data[ROW_W-1:0];
      expect_reg(regsel, PDATA_W'(cfg_height));
    end
  endtask

  // One frame setting: program both sizes, stream the given pixel count, drain
  task automatic run_setting(input logic [PDATA_W-1:0] w_word, input logic [PDATA_W-1:0] h_word,
                             input int unsigned count, input fill_mode_t mode);
    program_reg(REG_FRAME_WIDTH, w_word);
    program_reg(REG_FRAME_HEIGHT, h_word);
    tx_steady = ($urandom_range(4) == 0);
    rx_steady = ($urandom_range(4) == 0);
    send_pixels(count, mode);
    settle_block();
    settings_run++;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_steady || $urandom_range(99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_span();
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_edges.size() == 0) begin
        flag_mismatch($sformatf("unexpected result x=%0d y=%0d level=%0d last=%0d",
                                pos_x, pos_y, edge_level, frame_last));
      end else begin
        want = pending_edges.pop_front();
        if (pos_x !== want.x || pos_y !== want.y || edge_level !== want.lvl ||
            frame_last !== want.last) begin
          flag_mismatch({
            $sformatf("result mismatch: expected x=%0d y=%0d level=%0d last=%0d,",
                      want.x, want.y, want.lvl, want.last),
            $sformatf(" got x=%0d y=%0d level=%0d last=%0d",
                      pos_x, pos_y, edge_level, frame_last)});
        end
      end
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned roll;
    int unsigned random_sent;
    rgb_t        px;
    in_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_results = 1'b0;
    mismatches = 0;
    pixels_sent = 0;
    results_checked = 0;
    settings_run = 0;
    random_sent = 0;
    last_rgb = '0;
    cfg_width = 13'd640;
    cfg_height = 16'd480;
    left_code = LVL_LOW;
    col_pos = 0;
    row_pos = 0;

    // Hold reset, then release it
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sizes after reset
    expect_reg(REG_FRAME_WIDTH, 32'd640);
    expect_reg(REG_FRAME_HEIGHT, 32'd480);

    // Directed frame
    program_reg(REG_FRAME_WIDTH, 32'd5);
    program_reg(REG_FRAME_HEIGHT, 32'd4);
    foreach (DIRECTED_ROWS[i]) begin
      px.r = DIRECTED_ROWS[i].red_ch;
      px.g = DIRECTED_ROWS[i].green_ch;
      px.b = DIRECTED_ROWS[i].blue_ch;
      send_pixel(px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].level);
    end
    settle_block();

    // Degenerate sizes: zero, one and two wide or high give no results; 3 x 3 gives one per frame
    run_setting(32'd0, 32'd0, 3, FILL_RANDOM);
    run_setting(32'd1, 32'd2, 4, FILL_RANDOM);
    run_setting(32'd2, 32'd5, 10, FILL_SATURATED);
    run_setting(32'd7, 32'd2, 14, FILL_RANDOM);
    run_setting(32'd3, 32'd1, 3, FILL_THRESHOLD);
    run_setting(32'd3, 32'd3, 18, FILL_RANDOM);

    // Full-height frame cut short by a height change in mid-frame
    program_reg(REG_FRAME_WIDTH, 32'hFFFF_E004);
    program_reg(REG_FRAME_HEIGHT, 32'hFFFF_FFFF);
    send_pixels(24, FILL_SATURATED);
    settle_block();
    program_reg(REG_FRAME_HEIGHT, 32'd3);
    send_pixels(4 + 12, FILL_PATCHES);
    settle_block();

    // Long hold-off on the result side while pixels keep coming
    hold_results = 1'b1;
    run_setting(32'd10, 32'd12, 120, FILL_PATCHES);

    // Random frame settings, mostly small
    while (random_sent < RANDOM_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        w = $urandom_range(12, 3);
        h = $urandom_range(10, 3);
      end else if (roll < 90) begin
        w = $urandom_range(64, 13);
        h = $urandom_range(5, 3);
      end else begin
        w = 3;
        h = 3;
      end
      frames = $urandom_range(3, 1);
      run_setting(w, h, frames * w * h, fill_mode_t'($urandom_range(3)));
      random_sent += frames * w * h;
    end

    // Saturated width: stop part way into the first row, then shrink the width
    // so the row wraps at once and a 5 x 3 frame finishes on top of it
    run_setting(32'hFFFF_FFFF, 32'd3, WIDE_PIXELS, FILL_PATCHES);
    program_reg(REG_FRAME_WIDTH, 32'd5);
    send_pixels(1 + 2 * 5, FILL_RANDOM);
    settle_block();

    $display("covered %0d pixels and %0d results over %0d frame settings,", pixels_sent,
             results_checked, settings_run);
    $display("sizes from degenerate to saturated width, with stalls, hold-off and mid-frame resizes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
